FILE: hdl/lcg48_pkg.sv
// lcg48_pkg: constants, command codes and the draw helper for the 48-bit LCG.
// Used by lcg48_step, lcg48_mod and lcg48_random_generator_top. No dependencies.
`timescale 1ns / 1ps
package lcg48_pkg;

    localparam int unsigned STATE_W    = 48;
    localparam int unsigned DIGIT_W    = 16;
    localparam int unsigned MULT_W     = 35;
    localparam int unsigned PROD_W     = DIGIT_W + MULT_W;
    localparam int unsigned DRAW_W     = 31;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned CNT_W      = 2;

    localparam logic [MULT_W-1:0]  LCG_MULT = 35'h5DEECE66D;
    localparam logic [STATE_W-1:0] LCG_ADD  = 48'd11;

    localparam logic [1:0] CMD_SEED    = 2'd0;
    localparam logic [1:0] CMD_NEXT    = 2'd1;
    localparam logic [1:0] CMD_BOUNDED = 2'd2;
    localparam logic [1:0] CMD_LONG    = 2'd3;

    // top nbits of the state, nbits saturated at 32, zero for nbits of zero
    function automatic logic [WORD_W-1:0] draw_top(input logic [STATE_W-1:0] st,
                                                   input logic [5:0] nbits);
        logic [5:0]         n;
        logic [STATE_W-1:0] sh;
        begin
            n  = (nbits > 6'd32) ? 6'd32 : nbits;
            sh = st >> (6'd48 - n);
            if (n == 6'd0) begin
                draw_top = '0;
            end else begin
                draw_top = sh[WORD_W-1:0];
            end
        end
    endfunction

endpackage

FILE: hdl/lcg48_step.sv
// lcg48_step: one LCG advance, state * 0x5DEECE66D + 11 mod 2^48.
// Shared 16x35 multiplier, one 16-bit digit of the state per cycle. Uses lcg48_pkg.
`timescale 1ns / 1ps
module lcg48_step (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [lcg48_pkg::STATE_W-1:0]  state_in,
    output logic                           done,
    output logic [lcg48_pkg::STATE_W-1:0]  state_out
);
    import lcg48_pkg::*;

    logic [STATE_W-1:0] opnd_reg, opnd_next;
    logic [STATE_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [PROD_W-1:0]  prod;
    logic [STATE_W-1:0] part;

    assign prod = {{MULT_W{1'b0}}, opnd_reg[DIGIT_W-1:0]} * {{DIGIT_W{1'b0}}, LCG_MULT};

    always_comb begin
        case (cnt_reg)
            2'd0:    part = prod[STATE_W-1:0];
            2'd1:    part = {prod[STATE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            2'd2:    part = {prod[DIGIT_W-1:0], {(2*DIGIT_W){1'b0}}};
            default: part = '0;
        endcase
    end

    always_comb begin
        opnd_next = opnd_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            opnd_next = state_in;
            acc_next  = LCG_ADD;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next  = acc_reg + part;
            opnd_next = opnd_reg >> DIGIT_W;
            cnt_next  = cnt_reg + 2'd1;
            if (cnt_reg == 2'd2) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        opnd_reg <= opnd_next;
        acc_reg  <= acc_next;
    end

    assign done      = done_reg;
    assign state_out = acc_reg;

endmodule

FILE: hdl/lcg48_mod.sv
// lcg48_mod: serial restoring remainder of a 31-bit value by a 31-bit divisor.
// One quotient bit per cycle. Uses lcg48_pkg.
`timescale 1ns / 1ps
module lcg48_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lcg48_pkg::DRAW_W-1:0]  dividend,
    input  logic [lcg48_pkg::DRAW_W-1:0]  divisor,
    output logic                          done,
    output logic [lcg48_pkg::DRAW_W-1:0]  remainder
);
    import lcg48_pkg::*;

    logic [DRAW_W-1:0] num_reg, num_next;
    logic [DRAW_W-1:0] den_reg, den_next;
    logic [DRAW_W-1:0] rem_reg, rem_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DRAW_W:0]   trial;

    assign trial = {rem_reg, num_reg[DRAW_W-1]};

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = 5'(DRAW_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DRAW_W'(trial - {1'b0, den_reg});
            end else begin
                rem_next = trial[DRAW_W-1:0];
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/lcg48_random_generator_top.sv
// lcg48_random_generator_top: 48-bit LCG generator, command sequencer and output register.
// Instantiates lcg48_step and lcg48_mod. Uses lcg48_pkg.
//
//  channel | dir | tdata                                  | tuser
//  s_      | in  | seed[47:0] bits[53:48] bound[84:54]    | command[1:0]
//  m_      | out | value[63:0]                            | error
//
// Set seed and a bounded int with zero bound answer directly. Next bits and next long
// advance the LCG through lcg48_step, next long twice; a bounded int advances it, then
// scales a power-of-two bound by a multiply, else runs the serial remainder unit and
// redraws the 31-bit value on each rejection, with the remainder rechecked in S_CHK.
// Reset clears the LCG state to zero. s_tready is low from acceptance until the result
// transaction completes; a stalled m_ side holds the result.
`timescale 1ns / 1ps
module lcg48_random_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // seed[47:0], bits[53:48], bound[84:54], zero pad
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value[63:0]
    output logic        m_tuser    // error
);
    import lcg48_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_DRAW = 3'd2;
    localparam logic [2:0] S_POW  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]          fsm_reg, fsm_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [5:0]          bits_reg, bits_next;
    logic [DRAW_W-1:0]   bound_reg, bound_next;
    logic [STATE_W-1:0]  lcg_reg, lcg_next;
    logic                half_reg, half_next;
    logic [WORD_W-1:0]   hi_reg, hi_next;
    logic [DRAW_W-1:0]   u_reg, u_next;
    logic [DRAW_W-1:0]   r_reg, r_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic                error_reg, error_next;
    logic                mvalid_reg, mvalid_next;

    logic                step_start, step_done;
    logic [STATE_W-1:0]  step_res;
    logic                mod_start, mod_done;
    logic [DRAW_W-1:0]   mod_rem;

    logic [47:0]         in_seed;
    logic [5:0]          in_bits;
    logic [DRAW_W-1:0]   in_bound;
    logic [61:0]         pow_prod;
    logic [WORD_W-1:0]   chk;
    logic [WORD_W-1:0]   lo_word;
    logic                is_pow2;

    assign in_seed  = s_tdata[47:0];
    assign in_bits  = s_tdata[53:48];
    assign in_bound = s_tdata[84:54];

    assign pow_prod = {31'b0, bound_reg} * {31'b0, u_reg};
    assign chk      = {1'b0, u_reg} - {1'b0, r_reg} + {1'b0, DRAW_W'(bound_reg - 31'd1)};
    assign lo_word  = lcg_reg[47:16];
    assign is_pow2  = (bound_reg & DRAW_W'(bound_reg - 31'd1)) == '0;

    lcg48_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (step_start),
        .state_in  (lcg_reg),
        .done      (step_done),
        .state_out (step_res)
    );

    lcg48_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (lcg_reg[47:17]),
        .divisor   (bound_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        fsm_next    = fsm_reg;
        cmd_next    = cmd_reg;
        bits_next   = bits_reg;
        bound_next  = bound_reg;
        lcg_next    = lcg_reg;
        half_next   = half_reg;
        hi_next     = hi_reg;
        u_next      = u_reg;
        r_next      = r_reg;
        value_next  = value_reg;
        error_next  = error_reg;
        mvalid_next = mvalid_reg;
        step_start  = 1'b0;
        mod_start   = 1'b0;
        case (fsm_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    bits_next  = in_bits;
                    bound_next = in_bound;
                    half_next  = 1'b0;
                    case (s_tuser)
                        CMD_SEED: begin
                            lcg_next    = in_seed ^ {13'b0, LCG_MULT};
                            value_next  = '0;
                            error_next  = 1'b0;
                            mvalid_next = 1'b1;
                            fsm_next    = S_OUT;
                        end
                        CMD_BOUNDED: begin
                            if (in_bound == '0) begin
                                value_next  = '0;
                                error_next  = 1'b1;
                                mvalid_next = 1'b1;
                                fsm_next    = S_OUT;
                            end else begin
                                step_start = 1'b1;
                                fsm_next   = S_STEP;
                            end
                        end
                        default: begin
                            step_start = 1'b1;
                            fsm_next   = S_STEP;
                        end
                    endcase
                end
            end
            S_STEP: begin
                if (step_done) begin
                    lcg_next = step_res;
                    fsm_next = S_DRAW;
                end
            end
            S_DRAW: begin
                case (cmd_reg)
                    CMD_NEXT: begin
                        value_next  = {32'b0, draw_top(lcg_reg, bits_reg)};
                        error_next  = 1'b0;
                        mvalid_next = 1'b1;
                        fsm_next    = S_OUT;
                    end
                    CMD_BOUNDED: begin
                        u_next = lcg_reg[47:17];
                        if (is_pow2) begin
                            fsm_next = S_POW;
                        end else begin
                            mod_start = 1'b1;
                            fsm_next  = S_DIV;
                        end
                    end
                    default: begin
                        if (!half_reg) begin
                            hi_next    = lo_word;
                            half_next  = 1'b1;
                            step_start = 1'b1;
                            fsm_next   = S_STEP;
                        end else begin
                            value_next  = {hi_reg - {31'b0, lo_word[31]}, lo_word};
                            error_next  = 1'b0;
                            mvalid_next = 1'b1;
                            fsm_next    = S_OUT;
                        end
                    end
                endcase
            end
            S_POW: begin
                value_next  = {33'b0, pow_prod[61:31]};
                error_next  = 1'b0;
                mvalid_next = 1'b1;
                fsm_next    = S_OUT;
            end
            S_DIV: begin
                if (mod_done) begin
                    r_next   = mod_rem;
                    fsm_next = S_CHK;
                end
            end
            S_CHK: begin
                if (chk[31]) begin
                    step_start = 1'b1;
                    fsm_next   = S_STEP;
                end else begin
                    value_next  = {33'b0, r_reg};
                    error_next  = 1'b0;
                    mvalid_next = 1'b1;
                    fsm_next    = S_OUT;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    fsm_next    = S_IDLE;
                end
            end
            default: begin
                mvalid_next = 1'b0;
                fsm_next    = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg    <= S_IDLE;
            mvalid_reg <= 1'b0;
            lcg_reg    <= '0;
            half_reg   <= 1'b0;
        end else begin
            fsm_reg    <= fsm_next;
            mvalid_reg <= mvalid_next;
            lcg_reg    <= lcg_next;
            half_reg   <= half_next;
        end
        cmd_reg   <= cmd_next;
        bits_reg  <= bits_next;
        bound_reg <= bound_next;
        hi_reg    <= hi_next;
        u_reg     <= u_next;
        r_reg     <= r_next;
        value_reg <= value_next;
        error_reg <= error_next;
    end

    assign s_tready = (fsm_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = error_reg;

`ifndef ASSERT_OFF
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error result with nonzero value");

    a_units_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step_done && mod_done))
        else $error("multiplier and remainder unit finished together");

    a_seed_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_SEED) |=> (m_tvalid && !m_tuser))
        else $error("seed transaction did not produce a result next cycle");
`endif

endmodule

FILE: bench/lcg48_checker.sv
// lcg48_checker: watches both stream channels of the LCG generator, predicts each result
// transaction from the accepted commands and compares value and error field by field.
// Uses lcg48_pkg for command codes and LCG constants.
`timescale 1ns / 1ps
module lcg48_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending
);
    import lcg48_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic        error;
    } draw_result_t;

    draw_result_t draw_q[$];
    logic [47:0]  lcg_q;
    int           fails = 0;

    // advance the generator, return the top nbits (saturated at 32)
    function automatic logic [31:0] next_draw(input logic [5:0] nbits);
        logic [5:0]  n;
        logic [47:0] sh;
        begin
            lcg_q = lcg_q * {13'd0, LCG_MULT} + LCG_ADD;
            n = (nbits > 6'd32) ? 6'd32 : nbits;
            if (n == 6'd0) begin
                return 32'd0;
            end
            sh = lcg_q >> (6'd48 - n);
            return sh[31:0];
        end
    endfunction

    function automatic logic [31:0] bounded_draw(input logic [30:0] bound);
        logic [31:0] b, m, u, r, s;
        logic [63:0] prod;
        begin
            b = {1'b0, bound};
            m = b - 32'd1;
            u = next_draw(6'd31);
            if ((b & m) == 32'd0) begin
                prod = {32'd0, b} * {32'd0, u};
                return prod[62:31];
            end
            r = u % b;
            s = u - r + m;
            // redraw while the signed 32-bit rejection test overflows
            while (s[31]) begin
                u = next_draw(6'd31);
                r = u % b;
                s = u - r + m;
            end
            return r;
        end
    endfunction

    function automatic logic [63:0] long_draw();
        logic [31:0] hi, lo;
        begin
            hi = next_draw(6'd32);
            lo = next_draw(6'd32);
            return {hi, 32'd0} + {{32{lo[31]}}, lo};
        end
    endfunction

    function automatic draw_result_t predict_draw(input logic [1:0] cmd,
                                                  input logic [87:0] data);
        draw_result_t res;
        logic [47:0]  seed;
        logic [5:0]   nbits;
        logic [30:0]  bound;
        begin
            res   = '0;
            seed  = data[47:0];
            nbits = data[53:48];
            bound = data[84:54];
            case (cmd)
                CMD_SEED: begin
                    lcg_q = seed ^ {13'd0, LCG_MULT};
                end
                CMD_NEXT: begin
                    res.value = {32'd0, next_draw(nbits)};
                end
                CMD_BOUNDED: begin
                    if (bound == 31'd0) begin
                        res.error = 1'b1;
                    end else begin
                        res.value = {32'd0, bounded_draw(bound)};
                    end
                end
                default: begin
                    res.value = long_draw();
                end
            endcase
            return res;
        end
    endfunction

    always @(posedge aclk) begin : watch
        draw_result_t want;
        if (!aresetn) begin
            lcg_q = '0;
            draw_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (draw_q.size() == 0) begin
                    $display("%0t: unexpected result transaction value %h error %b",
                             $time, m_tdata, m_tuser);
                    fails++;
                end else begin
                    want = draw_q.pop_front();
                    if (m_tdata !== want.value) begin
                        $display("%0t: value mismatch expected %h actual %h",
                                 $time, want.value, m_tdata);
                        fails++;
                    end
                    if (m_tuser !== want.error) begin
                        $display("%0t: error mismatch expected %b actual %b",
                                 $time, want.error, m_tuser);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                draw_q.push_back(predict_draw(s_tuser, s_tdata));
            end
        end
        pending    <= draw_q.size();
        fail_count <= fails;
    end

endmodule

FILE: bench/tb_lcg48_random_generator_top.sv
// tb_lcg48_random_generator_top: command stimulus, random idling on both channels and
// the verdict for lcg48_random_generator_top. Uses lcg48_checker and lcg48_pkg.
`timescale 1ns / 1ps
module tb_lcg48_random_generator_top;
    import lcg48_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = CMD_SEED;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        idle_en  = 1'b0;
    int unsigned ready_hold = 0;
    int          fail_count;
    int          pending;

    lcg48_random_generator_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lcg48_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned gap_len();
        int unsigned r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                return 0;
            end else if (r < 85) begin
                return $urandom_range(1, 3);
            end else if (r < 97) begin
                return $urandom_range(4, 12);
            end
            return $urandom_range(20, 60);
        end
    endfunction

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!idle_en || !m_tready) begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 8);
        end else begin
            m_tready   <= 1'b0;
            ready_hold <= gap_len();
        end
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [47:0] seed,
                            input logic [5:0] nbits, input logic [30:0] bound);
        int unsigned gap;
        begin
            s_tvalid <= 1'b1;
            s_tuser  <= cmd;
            s_tdata  <= {3'b000, bound, nbits, seed};
            @(posedge aclk);
            while (!s_tready) begin
                @(posedge aclk);
            end
            gap = idle_en ? gap_len() : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_random();
        logic [1:0]  cmd;
        logic [47:0] seed;
        logic [5:0]  nbits;
        logic [30:0] bound;
        int unsigned pick;
        begin
            seed  = 48'({$urandom(), $urandom()});
            nbits = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(1, 32))
                                                 : 6'($urandom_range(0, 63));
            pick  = $urandom_range(0, 99);
            if (pick < 3) begin
                bound = '0;
            end else if (pick < 23) begin
                bound = 31'd1 << $urandom_range(0, 30);
            end else if (pick < 48) begin
                bound = 31'($urandom_range(1, 100));
            end else if (pick < 73) begin
                bound = 31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
            end else begin
                bound = 31'($urandom());
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                cmd = CMD_SEED;
            end else if (pick < 35) begin
                cmd = CMD_NEXT;
            end else if (pick < 75) begin
                cmd = CMD_BOUNDED;
            end else begin
                cmd = CMD_LONG;
            end
            send_cmd(cmd, seed, nbits, bound);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // draws straight from the reset state, then edges of every field
        send_cmd(CMD_NEXT,    48'h0,            6'd32, 31'd0);
        send_cmd(CMD_NEXT,    48'h0,            6'd0,  31'd0);
        send_cmd(CMD_LONG,    48'h0,            6'd0,  31'd0);
        send_cmd(CMD_BOUNDED, 48'h0,            6'd0,  31'd16);
        send_cmd(CMD_SEED,    48'h0,            6'd0,  31'd0);
        send_cmd(CMD_NEXT,    48'hFFFF_FFFF_FFFF, 6'd1, 31'h7FFF_FFFF);
        send_cmd(CMD_NEXT,    48'h0,            6'd32, 31'd0);
        send_cmd(CMD_NEXT,    48'h0,            6'd33, 31'd0);
        send_cmd(CMD_NEXT,    48'h0,            6'd63, 31'd0);
        send_cmd(CMD_BOUNDED, 48'hFFFF_FFFF_FFFF, 6'd63, 31'd0);
        send_cmd(CMD_BOUNDED, 48'h0,            6'd0,  31'd1);
        send_cmd(CMD_BOUNDED, 48'h0,            6'd0,  31'h4000_0000);
        send_cmd(CMD_BOUNDED, 48'h0,            6'd0,  31'h7FFF_FFFF);
        send_cmd(CMD_BOUNDED, 48'h0,            6'd0,  31'd7);
        send_cmd(CMD_BOUNDED, 48'h0,            6'd0,  31'd3);
        send_cmd(CMD_SEED,    48'hFFFF_FFFF_FFFF, 6'd0, 31'd0);
        send_cmd(CMD_LONG,    48'hFFFF_FFFF_FFFF, 6'd63, 31'h7FFF_FFFF);
        send_cmd(CMD_BOUNDED, 48'h0,            6'd0,  31'h4000_0001);
        send_cmd(CMD_NEXT,    48'h0,            6'd31, 31'd0);
        send_cmd(CMD_SEED,    {13'd0, LCG_MULT}, 6'd0, 31'd0);
        send_cmd(CMD_LONG,    48'h0,            6'd0,  31'd0);
        send_cmd(CMD_BOUNDED, 48'h0,            6'd0,  31'd1_500_000_001);
        send_cmd(CMD_LONG,    48'h0,            6'd0,  31'd0);

        for (int i = 0; i < 1850; i++) begin
            if (i % 300 == 0) begin
                idle_en <= ((i / 300) % 3 != 0);
            end
            send_random();
        end
        s_tvalid <= 1'b0;
        idle_en  <= 1'b0;

        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (100) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
